[rtl/rgb565_luma_nearest_downscaler_macros.svh]
// Assertion macros for the RGB565 luma downscaler checker.
// Self-contained; used by rlnd_checker.sv.
`ifndef RGB565_LUMA_NEAREST_DOWNSCALER_MACROS_SVH
`define RGB565_LUMA_NEAREST_DOWNSCALER_MACROS_SVH

// Same-cycle implication under a synchronous reset.
`define RLND_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlnd assertion failed");

// Next-cycle implication under a synchronous reset.
`define RLND_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlnd assertion failed");

`endif

[rtl/rlnd_pkg.sv]
// Shared types, constants and pixel functions for the RGB565 luma downscaler.
// No dependencies.
`default_nettype none
package rlnd_pkg;

   localparam int unsigned OUT_WIDTH  = 160;
   localparam int unsigned OUT_HEIGHT = 120;

   localparam int unsigned SRC_W   = 11;
   localparam int unsigned COL_W   = 8;
   localparam int unsigned ROW_W   = 7;
   localparam int unsigned IDX_W   = 8;
   localparam int unsigned PROD_W  = IDX_W + SRC_W;
   localparam int unsigned ADDR_W  = 3;
   localparam int unsigned DATA_W  = 32;

   // The pick divides by OUT_WIDTH or OUT_HEIGHT through a reciprocal multiply, and 26
   // fraction bits keep the quotient exact for every product of an index and a size.
   localparam int unsigned RECIP_SHIFT = 26;
   localparam int unsigned SCALE_W     = PROD_W + RECIP_SHIFT;

   localparam logic REG_SOURCE_WIDTH  = 1'b0;
   localparam logic REG_SOURCE_HEIGHT = 1'b1;

   typedef struct packed {
      logic [15:0] pixel;
      logic        frame_start;
   } req_data_type;

   typedef struct packed {
      logic [7:0]       luma;
      logic [COL_W-1:0] out_column;
      logic [ROW_W-1:0] out_row;
      logic             frame_last;
   } rsp_data_type;

   typedef struct packed {
      logic [SRC_W-1:0] source_width;
      logic [SRC_W-1:0] source_height;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_SCALE,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic mult;
      logic scale;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic emit_ok;
      logic busy_calc;
   } stat_type;

   // Widen a 5-bit channel to floor(v*255/31): 8*v plus floor(7*v/31).
   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [2:0] frac;
      frac = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
           + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
      return {v, 3'b000} + {5'b00000, frac};
   endfunction

   // Widen a 6-bit channel to floor(v*255/63): 4*v plus floor(v/21).
   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [1:0] frac;
      frac = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
      return {v, 2'b00} + {6'b000000, frac};
   endfunction

   function automatic logic [7:0] luma_of(input logic [15:0] px);
      logic [15:0] acc;
      acc = {8'h00, expand5(px[15:11])} * 16'd77
          + {8'h00, expand6(px[10:5])} * 16'd150
          + {8'h00, expand5(px[4:0])} * 16'd29;
      return acc[15:8];
   endfunction

endpackage
`default_nettype wire

[rtl/rlnd_csr.sv]
// Configuration registers (source width and height) behind an APB-style port.
// Depends on rlnd_pkg.
`default_nettype none
module rlnd_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [rlnd_pkg::ADDR_W-1:0] paddr,
   input  wire logic [rlnd_pkg::DATA_W-1:0] pwdata,
   output logic      [rlnd_pkg::DATA_W-1:0] prdata,
   output logic                            pready,
   output rlnd_pkg::cfg_type               cfg
);
   import rlnd_pkg::*;

   logic [SRC_W-1:0] width_ff, width_in;
   logic [SRC_W-1:0] height_ff, height_in;
   logic             wr_en;

   assign wr_en = psel & penable & pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_SOURCE_WIDTH:  width_in  = pwdata[SRC_W-1:0];
            REG_SOURCE_HEIGHT: height_in = pwdata[SRC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SRC_W'(320);
         height_ff <= SRC_W'(240);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_SOURCE_WIDTH:  prdata = DATA_W'(width_ff);
         REG_SOURCE_HEIGHT: prdata = DATA_W'(height_ff);
         default:           prdata = '0;
      endcase
   end

   assign pready            = 1'b1;
   assign cfg.source_width  = width_ff;
   assign cfg.source_height = height_ff;

endmodule
`default_nettype wire

[rtl/rlnd_ctrl.sv]
// Controller state machine: accepts one pixel, steps the pick calculation, emits.
// Depends on rlnd_pkg.
`default_nettype none
module rlnd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire rlnd_pkg::stat_type stat,
   output rlnd_pkg::cmd_type       cmd
);
   import rlnd_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MULT;
         end
         ST_MULT:  state_in = ST_SCALE;
         ST_SCALE: state_in = stat.emit_ok ? ST_IDLE : ST_WAIT;
         ST_WAIT:  state_in = stat.emit_ok ? ST_IDLE : ST_WAIT;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = reset;
            cmd.accept = req_valid & ~reset;
         end
         ST_MULT:  cmd.mult = stat.busy_calc;
         ST_SCALE: begin
            cmd.scale = stat.busy_calc;
            cmd.emit  = stat.emit_ok;
         end
         ST_WAIT:  cmd.emit = stat.emit_ok;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[rtl/rlnd_dpath.sv]
// Datapath: position counters, pick multiply and scale, luma and result register.
// Depends on rlnd_pkg.
`default_nettype none
module rlnd_dpath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rlnd_pkg::cmd_type      cmd,
   output rlnd_pkg::stat_type          stat,
   input  wire rlnd_pkg::cfg_type      cfg,
   input  wire rlnd_pkg::req_data_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rlnd_pkg::rsp_data_type      rsp_data
);
   import rlnd_pkg::*;

   // Reciprocals for the two output sizes, exact over the product range.
   localparam logic [RECIP_SHIFT-1:0] RECIP_COL =
      RECIP_SHIFT'(((1 << RECIP_SHIFT) + OUT_WIDTH - 1) / OUT_WIDTH);
   localparam logic [RECIP_SHIFT-1:0] RECIP_ROW =
      RECIP_SHIFT'(((1 << RECIP_SHIFT) + OUT_HEIGHT - 1) / OUT_HEIGHT);

   logic [SRC_W-1:0] src_col_ff, src_col_in;
   logic [SRC_W-1:0] src_row_ff, src_row_in;
   logic [COL_W-1:0] dst_col_ff, dst_col_in;
   logic [ROW_W-1:0] dst_row_ff, dst_row_in;
   logic [SRC_W-1:0] pick_col_ff, pick_col_in;
   logic [SRC_W-1:0] pick_row_ff, pick_row_in;
   logic             hit_ff, calc_ff, calc_row_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      pixel_ff;
   logic [COL_W-1:0] out_col_ff;
   logic [ROW_W-1:0] out_row_ff;
   logic             last_ff;
   logic [IDX_W-1:0] mul_idx_ff;
   logic [PROD_W-1:0] prod_ff;
   rsp_data_type     rsp_data_ff;

   logic [SRC_W-1:0] src_col_eff, src_row_eff, pick_col_eff, pick_row_eff;
   logic [COL_W-1:0] dst_col_eff;
   logic [ROW_W-1:0] dst_row_eff;
   logic             row_hit, col_hit, row_end, last;
   logic [SRC_W-1:0] mul_size;
   logic [SCALE_W-1:0] scaled;
   logic [SRC_W-1:0] pick_new;

   always_comb begin
      if (req_data.frame_start) begin
         src_col_eff  = '0;
         src_row_eff  = '0;
         dst_col_eff  = '0;
         dst_row_eff  = '0;
         pick_col_eff = '0;
         pick_row_eff = '0;
      end else begin
         src_col_eff  = src_col_ff;
         src_row_eff  = src_row_ff;
         dst_col_eff  = dst_col_ff;
         dst_row_eff  = dst_row_ff;
         pick_col_eff = pick_col_ff;
         pick_row_eff = pick_row_ff;
      end
   end

   assign row_hit = (dst_row_eff < ROW_W'(OUT_HEIGHT)) && (src_row_eff == pick_row_eff);
   assign col_hit = row_hit && (dst_col_eff < COL_W'(OUT_WIDTH))
                 && (src_col_eff == pick_col_eff);
   assign row_end = ({1'b0, src_col_eff} + (SRC_W+1)'(1)) >= {1'b0, cfg.source_width};
   assign last    = (dst_col_eff == COL_W'(OUT_WIDTH - 1))
                 && (dst_row_eff == ROW_W'(OUT_HEIGHT - 1));

   assign mul_size = calc_row_ff ? cfg.source_height : cfg.source_width;
   assign scaled   = SCALE_W'(prod_ff)
                   * SCALE_W'(calc_row_ff ? RECIP_ROW : RECIP_COL);
   assign pick_new = scaled[RECIP_SHIFT +: SRC_W];

   always_comb begin
      src_col_in  = src_col_ff;
      src_row_in  = src_row_ff;
      dst_col_in  = dst_col_ff;
      dst_row_in  = dst_row_ff;
      pick_col_in = pick_col_ff;
      pick_row_in = pick_row_ff;
      if (cmd.accept) begin
         src_row_in  = src_row_eff;
         dst_row_in  = dst_row_eff;
         pick_row_in = pick_row_eff;
         if (row_end) begin
            src_col_in  = '0;
            src_row_in  = src_row_eff + SRC_W'(1);
            dst_col_in  = '0;
            pick_col_in = '0;
            if (row_hit) dst_row_in = dst_row_eff + ROW_W'(1);
         end else begin
            src_col_in  = src_col_eff + SRC_W'(1);
            dst_col_in  = col_hit ? dst_col_eff + COL_W'(1) : dst_col_eff;
            pick_col_in = pick_col_eff;
         end
      end else if (cmd.scale) begin
         if (calc_row_ff) pick_row_in = pick_new;
         else             pick_col_in = pick_new;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit && hit_ff) rsp_valid_in = 1'b1;
      else if (!rsp_stall)    rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         dst_col_ff   <= '0;
         dst_row_ff   <= '0;
         pick_col_ff  <= '0;
         pick_row_ff  <= '0;
         hit_ff       <= 1'b0;
         calc_ff      <= 1'b0;
         calc_row_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         dst_col_ff   <= dst_col_in;
         dst_row_ff   <= dst_row_in;
         pick_col_ff  <= pick_col_in;
         pick_row_ff  <= pick_row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.accept) begin
            hit_ff      <= col_hit;
            calc_ff     <= row_end ? row_hit : col_hit;
            calc_row_ff <= row_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pixel_ff   <= req_data.pixel;
         out_col_ff <= dst_col_eff;
         out_row_ff <= dst_row_eff;
         last_ff    <= last;
         mul_idx_ff <= row_end ? IDX_W'(dst_row_eff) + IDX_W'(1) : dst_col_eff + IDX_W'(1);
      end
      if (cmd.mult) begin
         prod_ff <= PROD_W'(mul_idx_ff) * PROD_W'(mul_size);
      end
      if (cmd.emit && hit_ff) begin
         rsp_data_ff.luma       <= luma_of(pixel_ff);
         rsp_data_ff.out_column <= out_col_ff;
         rsp_data_ff.out_row    <= out_row_ff;
         rsp_data_ff.frame_last <= last_ff;
      end
   end

   assign stat.emit_ok   = ~hit_ff | ~rsp_valid_ff | ~rsp_stall;
   assign stat.busy_calc = calc_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_data_ff;

endmodule
`default_nettype wire

[rtl/rgb565_luma_nearest_downscaler.sv]
// RGB565 to 8-bit luma converter with nearest-neighbor downscaling to 160x120.
// A selected pixel's result is registered from ST_SCALE, or from ST_WAIT once a
// stalled earlier result is taken. A new pixel is taken only in ST_IDLE, after
// ST_MULT and ST_SCALE of the shared pick multiply and reciprocal-scale path.
// Reset is synchronous: counters clear, source size returns to 320x240.
// Depends on rlnd_pkg, rlnd_csr, rlnd_ctrl and rlnd_dpath.
`default_nettype none
module rgb565_luma_nearest_downscaler (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire rlnd_pkg::req_data_type     req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rlnd_pkg::rsp_data_type          rsp_data,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [rlnd_pkg::ADDR_W-1:0] paddr,
   input  wire logic [rlnd_pkg::DATA_W-1:0] pwdata,
   output logic      [rlnd_pkg::DATA_W-1:0] prdata,
   output logic                            pready
);
   import rlnd_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   rlnd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rlnd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rlnd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .cfg       (cfg),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[rtl/rlnd_checker.sv]
// Port-level checker for the RGB565 luma downscaler, bound to the top level.
// Depends on rlnd_pkg and rgb565_luma_nearest_downscaler_macros.svh.
`default_nettype none
`include "rgb565_luma_nearest_downscaler_macros.svh"
module rlnd_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire rlnd_pkg::rsp_data_type rsp_data
);
   import rlnd_pkg::*;

   `RLND_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `RLND_ASSERT_NXT(a_busy_after_transfer, clock, reset, req_valid && !req_stall, req_stall)
   `RLND_ASSERT_IMP(a_rsp_in_range, clock, reset, rsp_valid, (rsp_data.out_column < COL_W'(OUT_WIDTH)) && (rsp_data.out_row < ROW_W'(OUT_HEIGHT)))
   `RLND_ASSERT_IMP(a_last_position, clock, reset, rsp_valid && rsp_data.frame_last, (rsp_data.out_column == COL_W'(OUT_WIDTH - 1)) && (rsp_data.out_row == ROW_W'(OUT_HEIGHT - 1)))

endmodule

bind rgb565_luma_nearest_downscaler rlnd_checker u_checker (.*);
`default_nettype wire
